// ----- hdl/mnv_pkg.sv -----
package mnv_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned CodeW  = 3;
    localparam int unsigned SInW   = 24;
    localparam int unsigned MOutW  = 32;
    localparam logic [ChanW-1:0] ChanMax = 8'd255;
    localparam logic [ChanW-1:0] ChanMid = 8'd128;

    // quadruple codes
    typedef enum logic [CodeW-1:0] {
        Q_CMYW = 3'd0,
        Q_MYGC = 3'd1,
        Q_RGMY = 3'd2,
        Q_KRGB = 3'd3,
        Q_RGBM = 3'd4,
        Q_CMGB = 3'd5
    } t_quad;

    // vertex codes
    typedef enum logic [CodeW-1:0] {
        V_BLACK   = 3'd0,
        V_BLUE    = 3'd1,
        V_GREEN   = 3'd2,
        V_RED     = 3'd3,
        V_CYAN    = 3'd4,
        V_MAGENTA = 3'd5,
        V_YELLOW  = 3'd6,
        V_WHITE   = 3'd7
    } t_vert;

    // comparison results of one pixel, passed from the compare stage
    typedef struct packed {
        t_quad quad;
        logic  r_hi;     // r >= 128
        logic  g_hi;
        logic  b_hi;
        logic  r_gt;     // r > 128
        logic  g_gt;
        logic  b_gt;
        logic  r_ge_g;
        logic  r_ge_b;
        logic  g_ge_b;
        logic  g_ge_r;
        logic  b_ge_r;
        logic  b_ge_g;
        logic  g_gt_br;  // g > b + r
        logic  rbg_ge;   // r - g + b >= 128
    } t_flags;

    // vertex colour as {red, green, blue} on/off bits
    function automatic logic [2:0] vertex_rgb(input t_vert v);
        logic [2:0] c;
        case (v)
            V_BLACK:   c = 3'b000;
            V_BLUE:    c = 3'b001;
            V_GREEN:   c = 3'b010;
            V_RED:     c = 3'b100;
            V_CYAN:    c = 3'b011;
            V_MAGENTA: c = 3'b101;
            V_YELLOW:  c = 3'b110;
            V_WHITE:   c = 3'b111;
            default:   c = 3'b000;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/mnv_cmp.sv -----
module mnv_cmp
    import mnv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_adv,
    input  logic [ChanW-1:0] i_red,
    input  logic [ChanW-1:0] i_green,
    input  logic [ChanW-1:0] i_blue,
    output logic             o_valid,
    output t_flags           o_flags
);

    logic               r_valid;
    t_flags             r_flags;
    t_flags             n_flags;
    logic [ChanW:0]     w_rg;
    logic [ChanW:0]     w_gb;
    logic [ChanW:0]     w_rb;
    logic [ChanW+1:0]   w_rgb;
    logic [ChanW+1:0]   w_g_mid;

    // form the channel sums
    always_comb begin
        w_rg    = {1'b0, i_red}   + {1'b0, i_green};
        w_gb    = {1'b0, i_green} + {1'b0, i_blue};
        w_rb    = {1'b0, i_red}   + {1'b0, i_blue};
        w_rgb   = {1'b0, w_rg} + {2'b00, i_blue};
        w_g_mid = {2'b00, i_green} + {2'b00, ChanMid};
    end

    // classify the quadruple and compare channels
    always_comb begin
        if (w_rg > {1'b0, ChanMax}) begin
            if (w_gb > {1'b0, ChanMax}) begin
                n_flags.quad = (w_rgb > {1'b0, ChanMax, 1'b0}) ? Q_CMYW : Q_MYGC;
            end else begin
                n_flags.quad = Q_RGMY;
            end
        end else if (w_gb <= {1'b0, ChanMax}) begin
            n_flags.quad = (w_rgb <= {2'b00, ChanMax}) ? Q_KRGB : Q_RGBM;
        end else begin
            n_flags.quad = Q_CMGB;
        end
        n_flags.r_hi    = i_red   >= ChanMid;
        n_flags.g_hi    = i_green >= ChanMid;
        n_flags.b_hi    = i_blue  >= ChanMid;
        n_flags.r_gt    = i_red   >  ChanMid;
        n_flags.g_gt    = i_green >  ChanMid;
        n_flags.b_gt    = i_blue  >  ChanMid;
        n_flags.r_ge_g  = i_red   >= i_green;
        n_flags.r_ge_b  = i_red   >= i_blue;
        n_flags.g_ge_b  = i_green >= i_blue;
        n_flags.g_ge_r  = i_green >= i_red;
        n_flags.b_ge_r  = i_blue  >= i_red;
        n_flags.b_ge_g  = i_blue  >= i_green;
        n_flags.g_gt_br = {1'b0, i_green} > w_rb;
        n_flags.rbg_ge  = {1'b0, w_rb} >= w_g_mid;
    end

    // hold the stage while the next one is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;

endmodule

// ----- hdl/mnv_tree.sv -----
module mnv_tree
    import mnv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  logic   i_adv,
    input  t_flags i_flags,
    output logic   o_valid,
    output t_quad  o_quad,
    output t_vert  o_vert
);

    logic   r_valid;
    t_quad  r_quad;
    t_vert  r_vert;
    t_vert  n_vert;
    t_flags f;

    assign f = i_flags;

    // walk the comparison tree of the selected quadruple
    always_comb begin
        n_vert = V_BLACK;
        case (f.quad)
            Q_CMYW: begin
                n_vert = V_WHITE;
                if (!f.b_hi && f.r_ge_b && f.g_ge_b) n_vert = V_YELLOW;
                if (!f.g_hi && f.b_ge_g && f.r_ge_g) n_vert = V_MAGENTA;
                if (!f.r_hi && f.b_ge_r && f.g_ge_r) n_vert = V_CYAN;
            end
            Q_MYGC: begin
                n_vert = V_MAGENTA;
                if (f.g_ge_b && f.r_ge_b) n_vert = f.r_hi ? V_YELLOW : V_GREEN;
                if (f.g_ge_r && f.b_ge_r) n_vert = f.b_hi ? V_CYAN : V_GREEN;
            end
            Q_RGMY: begin
                if (f.b_gt) begin
                    if (f.r_gt) n_vert = f.b_ge_g ? V_MAGENTA : V_YELLOW;
                    else        n_vert = f.g_gt_br ? V_GREEN : V_MAGENTA;
                end else if (f.r_hi) begin
                    n_vert = f.g_hi ? V_YELLOW : V_RED;
                end else begin
                    n_vert = f.r_ge_g ? V_RED : V_GREEN;
                end
            end
            Q_KRGB: begin
                n_vert = V_BLACK;
                if (f.b_gt && f.b_ge_r && f.b_ge_g) n_vert = V_BLUE;
                if (f.g_gt && f.g_ge_b && f.g_ge_r) n_vert = V_GREEN;
                if (f.r_gt && f.r_ge_b && f.r_ge_g) n_vert = V_RED;
            end
            Q_RGBM: begin
                n_vert = V_GREEN;
                if (!f.g_ge_r && f.r_ge_b) n_vert = f.b_hi ? V_MAGENTA : V_RED;
                if (!f.g_ge_b && f.b_ge_r) n_vert = f.r_hi ? V_MAGENTA : V_BLUE;
            end
            Q_CMGB: begin
                if (f.b_gt) begin
                    if (f.r_gt) n_vert = f.g_ge_r ? V_CYAN : V_MAGENTA;
                    else        n_vert = f.g_gt ? V_CYAN : V_BLUE;
                end else if (f.r_gt) begin
                    n_vert = f.rbg_ge ? V_MAGENTA : V_GREEN;
                end else begin
                    n_vert = f.g_ge_b ? V_GREEN : V_BLUE;
                end
            end
            default: n_vert = V_BLACK;
        endcase
    end

    // hold the stage while the next one is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_quad <= f.quad;
            r_vert <= n_vert;
        end
    end

    assign o_valid = r_valid;
    assign o_quad  = r_quad;
    assign o_vert  = r_vert;

endmodule

// ----- hdl/mbvq_nearest_vertex.sv -----
// Nearest-vertex quantizer for colour error diffusion: each RGB pixel is put
// into one of six minimum-brightness-variation quadruples and mapped to the
// nearest RGB-cube vertex of that quadruple. Three register stages (channel
// sums and compares, quadruple tree, vertex colour) lie between request and
// result; a new pixel is taken every cycle while the output side keeps
// taking results. A stage holds only while every stage after it is full, so
// o_s_tready drops only when all three stages hold data and i_m_tready is
// low.
module mbvq_nearest_vertex
    import mnv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [SInW-1:0]  i_s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [MOutW-1:0] o_m_tdata    // quadruple_code[2:0], vertex_code[5:3],
                                          // red_out[13:6], green_out[21:14],
                                          // blue_out[29:22], zero[31:30]
);

    logic             w_adv1;
    logic             w_adv2;
    logic             w_adv3;
    logic             w_v1;
    logic             w_v2;
    t_flags           w_flags;
    t_quad            w_quad;
    t_vert            w_vert;
    logic [2:0]       w_rgb;
    logic             r_valid;
    t_quad            r_quad;
    t_vert            r_vert;
    logic [ChanW-1:0] r_red;
    logic [ChanW-1:0] r_green;
    logic [ChanW-1:0] r_blue;

    // advance a stage when it is empty or the stage after it advances
    assign w_adv3     = !r_valid || i_m_tready;
    assign w_adv2     = !w_v2 || w_adv3;
    assign w_adv1     = !w_v1 || w_adv2;
    assign o_s_tready = w_adv1;

    mnv_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_adv   (w_adv1),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_valid (w_v1),
        .o_flags (w_flags)
    );

    mnv_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .i_adv   (w_adv2),
        .i_flags (w_flags),
        .o_valid (w_v2),
        .o_quad  (w_quad),
        .o_vert  (w_vert)
    );

    assign w_rgb = vertex_rgb(w_vert);

    // output stage: expand the vertex to full-scale channels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv3) begin
            r_valid <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_quad  <= w_quad;
            r_vert  <= w_vert;
            r_red   <= w_rgb[2] ? ChanMax : '0;
            r_green <= w_rgb[1] ? ChanMax : '0;
            r_blue  <= w_rgb[0] ? ChanMax : '0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_blue, r_green, r_red, r_vert, r_quad};

    // input stalls only when the whole pipeline is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_valid && w_v2 && w_v1 && !i_m_tready))
        else $error("input stalled with a free stage");

    // channels are full scale or zero
    a_chan_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_red == ChanMax || r_red == '0)
                     && (r_green == ChanMax || r_green == '0)
                     && (r_blue == ChanMax || r_blue == '0)))
        else $error("vertex channel not full scale");

    // dark quadruple picks only black or a primary
    a_krgb_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_quad == Q_KRGB) |->
            (r_vert == V_BLACK || r_vert == V_BLUE || r_vert == V_GREEN
             || r_vert == V_RED))
        else $error("KRGB quadruple gave a foreign vertex");

    // bright quadruple picks only white or a secondary
    a_cmyw_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_quad == Q_CMYW) |->
            (r_vert == V_WHITE || r_vert == V_CYAN || r_vert == V_MAGENTA
             || r_vert == V_YELLOW))
        else $error("CMYW quadruple gave a foreign vertex");

endmodule
